@@ sv/dq_pkg.sv @@
// Package: shared types and constants for the double-ended queue.
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DEPTH  = 1024;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // request codes; anything above REQ_QUERY behaves as a query
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_QUERY      = 3'd4;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [DATA_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic                     popped_valid;
        logic                     error;
        logic [CNT_W-1:0]         element_count;
        logic                     is_empty;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic                     ends_valid;
    } res_t;

    // per-cycle command broadcast to every cell of one chain
    typedef struct packed {
        logic shift_right;  // take left neighbor (cell 0 takes din)
        logic shift_left;   // take right neighbor
        logic append;       // the cell at slot takes din
    } cell_ctl_t;

endpackage

@@ sv/dq_cell.sv @@
// One storage cell of a deque shift chain.
`timescale 1ns / 1ps

module dq_cell
    import dq_pkg::*;
(
    input  logic                     clk,
    input  cell_ctl_t                ctl,
    input  logic [IDX_W-1:0]         slot,
    input  logic [IDX_W-1:0]         idx,
    input  logic signed [DATA_W-1:0] din,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0] data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        priority if (ctl.shift_right)
        begin
            data_next = left_data;
        end
        else if (ctl.shift_left)
        begin
            data_next = right_data;
        end
        else if (ctl.append && (slot == idx))
        begin
            data_next = din;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ sv/dq_chain.sv @@
// Row of DEPTH cells; element 0 of the row is the head of this chain.
`timescale 1ns / 1ps

module dq_chain
    import dq_pkg::*;
(
    input  logic                     clk,
    input  cell_ctl_t                ctl,
    input  logic [IDX_W-1:0]         slot,
    input  logic signed [DATA_W-1:0] din,
    output logic signed [DATA_W-1:0] head
);

    logic signed [DATA_W-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_in;
        logic signed [DATA_W-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = din;
        end
        else
        begin : g_mid_l
            assign left_in = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_r
            assign right_in = cell_data[i+1];
        end

        dq_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .slot       (slot),
            .idx        (IDX_W'(i)),
            .din        (din),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

@@ sv/double_ended_queue.sv @@
// Top level: bounded double-ended queue built from two shift chains of cells.
`timescale 1ns / 1ps
// The result beat for a request accepted at an edge is on res in the cycle after that edge.
// Throughput: one request per cycle; all chain cells update together, so busy is low.
// Reset: rst_n (async, active low) clears the count and the result strobe; cell data is not reset.
// The receiver cannot stall: each result beat is shown for exactly one cycle with done high.

module double_ended_queue
    import dq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output res_t res
);

    // Two chains hold the same elements. The forward chain keeps the front
    // element in its cell 0; the reverse chain keeps the back element in its
    // cell 0. A push or pop at one end shifts the chain whose head is at that
    // end and appends or drops at the tail of the other chain, so every end
    // value is read from a fixed cell.

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     done_reg;
    logic signed [DATA_W-1:0] popped_value_reg;
    logic signed [DATA_W-1:0] popped_value_next;
    logic                     popped_valid_reg;
    logic                     popped_valid_next;
    logic                     error_reg;
    logic                     error_next;

    cell_ctl_t                fwd_ctl;
    cell_ctl_t                rev_ctl;
    logic signed [DATA_W-1:0] fwd_head;
    logic signed [DATA_W-1:0] rev_head;

    logic accept;
    logic full;
    logic empty;

    assign busy   = 1'b0;   // a new beat can follow every cycle
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        fwd_ctl           = '0;
        rev_ctl           = '0;
        count_next        = count_reg;
        popped_value_next = '0;
        popped_valid_next = 1'b0;
        error_next        = 1'b0;

        if (accept)
        begin
            unique case (req.req_type)
                REQ_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        fwd_ctl.shift_right = 1'b1;
                        rev_ctl.append      = 1'b1;
                        count_next          = count_reg + 1'b1;
                    end
                end
                REQ_PUSH_BACK:
                begin
                    if (full)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        fwd_ctl.append      = 1'b1;
                        rev_ctl.shift_right = 1'b1;
                        count_next          = count_reg + 1'b1;
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (empty)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        // the reverse chain's stale tail cell drops out by count
                        fwd_ctl.shift_left = 1'b1;
                        popped_value_next  = fwd_head;
                        popped_valid_next  = 1'b1;
                        count_next         = count_reg - 1'b1;
                    end
                end
                REQ_POP_BACK:
                begin
                    if (empty)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        rev_ctl.shift_left = 1'b1;
                        popped_value_next  = rev_head;
                        popped_valid_next  = 1'b1;
                        count_next         = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    // query and unused codes leave the state alone
                end
            endcase
        end
    end

    // append slot is the current count; only used when not full
    dq_chain u_fwd (
        .clk  (clk),
        .ctl  (fwd_ctl),
        .slot (count_reg[IDX_W-1:0]),
        .din  (req.push_value),
        .head (fwd_head)
    );

    dq_chain u_rev (
        .clk  (clk),
        .ctl  (rev_ctl),
        .slot (count_reg[IDX_W-1:0]),
        .din  (req.push_value),
        .head (rev_head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_value_reg <= popped_value_next;
        popped_valid_reg <= popped_valid_next;
        error_reg        <= error_next;
    end

    // result beat: chain heads already show the post-request ends
    assign done = done_reg;

    always_comb
    begin
        res.popped_value  = popped_value_reg;
        res.popped_valid  = popped_valid_reg;
        res.error         = error_reg;
        res.element_count = count_reg;
        res.is_empty      = empty;
        res.front_value   = empty ? '0 : fwd_head;
        res.back_value    = empty ? '0 : rev_head;
        res.ends_valid    = !empty;
    end

endmodule

@@ bench/deque_checker.sv @@
// Checker: predicts each deque result beat from the accepted request and compares it.
`timescale 1ns / 1ps

module deque_checker
    import dq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  req_t req,
    input  logic done,
    input  res_t res,
    output int   mismatches,
    output int   pending
);

    localparam int BEAT_SLOTS = 16;  // far more than the one beat in flight

    // shadow ring buffer
    logic signed [DATA_W-1:0] slots [DEPTH];
    int   head_idx;
    int   fill;

    // predicted beats waiting for their result, oldest at beat_rd
    res_t expected_beats [BEAT_SLOTS];
    int   beat_wr;
    int   beat_rd;

    function automatic int wrap(input int idx);
        return (idx + DEPTH) % DEPTH;
    endfunction

    // updates the shadow deque and returns the beat the block must produce
    function automatic res_t apply_request(input req_t r);
        res_t o;
        o = '0;
        case (r.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                if (fill == DEPTH)
                begin
                    o.error = 1'b1;
                end
                else
                begin
                    if (r.req_type == REQ_PUSH_FRONT)
                    begin
                        head_idx = wrap(head_idx - 1);
                        slots[head_idx] = r.push_value;
                    end
                    else
                    begin
                        slots[wrap(head_idx + fill)] = r.push_value;
                    end
                    fill++;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                if (fill == 0)
                begin
                    o.error = 1'b1;
                end
                else
                begin
                    o.popped_valid = 1'b1;
                    if (r.req_type == REQ_POP_FRONT)
                    begin
                        o.popped_value = slots[head_idx];
                        head_idx = wrap(head_idx + 1);
                    end
                    else
                    begin
                        o.popped_value = slots[wrap(head_idx + fill - 1)];
                    end
                    fill--;
                end
            end
            default:
            begin
                // query and spare codes leave the deque alone
            end
        endcase
        o.element_count = CNT_W'(fill);
        o.is_empty      = (fill == 0);
        if (fill != 0)
        begin
            o.front_value = slots[head_idx];
            o.back_value  = slots[wrap(head_idx + fill - 1)];
            o.ends_valid  = 1'b1;
        end
        return o;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        if (!rst_n)
        begin
            head_idx   = 0;
            fill       = 0;
            mismatches = 0;
            beat_wr    = 0;
            beat_rd    = 0;
        end
        else
        begin
            if (done)
            begin
                if (beat_wr == beat_rd)
                begin
                    $error("result beat with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_beats[beat_rd % BEAT_SLOTS];
                    beat_rd++;
                    check_field("popped_value", $signed(want.popped_value),
                                $signed(res.popped_value));
                    check_field("popped_valid", want.popped_valid, res.popped_valid);
                    check_field("error", want.error, res.error);
                    check_field("element_count", want.element_count, res.element_count);
                    check_field("is_empty", want.is_empty, res.is_empty);
                    check_field("front_value", $signed(want.front_value),
                                $signed(res.front_value));
                    check_field("back_value", $signed(want.back_value),
                                $signed(res.back_value));
                    check_field("ends_valid", want.ends_valid, res.ends_valid);
                end
            end
            if (start && !busy)
            begin
                if (beat_wr - beat_rd >= BEAT_SLOTS)
                begin
                    $error("too many result beats outstanding");
                    mismatches++;
                end
                else
                begin
                    expected_beats[beat_wr % BEAT_SLOTS] = apply_request(req);
                    beat_wr++;
                end
            end
        end
        pending = beat_wr - beat_rd;
    end

endmodule

@@ bench/double_ended_queue_tb.sv @@
// Testbench top: drives deque requests and reports the verdict from the checker.
`timescale 1ns / 1ps

module double_ended_queue_tb;
    import dq_pkg::*;

    // request codes above REQ_QUERY; the block must treat them as queries
    localparam logic [2:0] REQ_SPARE_A = 3'd5;
    localparam logic [2:0] REQ_SPARE_B = 3'd6;
    localparam logic [2:0] REQ_SPARE_C = 3'd7;

    localparam int IDLE_PCT     = 13;    // sender idles in this share of cycles
    localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int TAIL_CYCLES  = 3;     // margin for the last result beat to arrive
    localparam int MIX_ITEMS    = 40;
    // push-heavy run long enough to hit full with a margin of refused pushes
    localparam int FILL_ITEMS   = 1080;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t req;
    res_t res;

    int mismatches;
    int pending;
    int stall_cycles = 0;
    bit idle_enable;

    double_ended_queue dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .res   (res)
    );

    deque_checker result_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .res        (res),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One request beat. Random idle cycles go in front of it while idling is on;
    // start stays high across back-to-back beats so it is never dropped and
    // raised in the same step. Returns right after the accepting edge.
    task automatic send_request(input logic [2:0] kind,
                                input logic signed [DATA_W-1:0] value);
        while (idle_enable && $urandom_range(99) < IDLE_PCT)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= '{req_type: kind, push_value: value};
        do
            @(posedge clk);
        while (busy);
    endtask

    // Random request: push_pct percent pushes, pop_pct percent pops, the rest
    // queries (the real query code half the time, a spare code otherwise).
    task automatic send_random(input int push_pct, input int pop_pct);
        int         roll;
        logic [2:0] kind;
        roll = $urandom_range(99);
        if (roll < push_pct)
        begin
            kind = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        end
        else if (roll < push_pct + pop_pct)
        begin
            kind = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
        end
        else
        begin
            case ($urandom_range(5))
                0:       kind = REQ_SPARE_A;
                1:       kind = REQ_SPARE_B;
                2:       kind = REQ_SPARE_C;
                default: kind = REQ_QUERY;
            endcase
        end
        send_request(kind, $urandom());
    endtask

    // Hold the sender off until every result beat is in. The checker's count
    // is read on the falling edge, after all rising-edge activity has settled.
    task automatic wait_until_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // Watchdog: any accepted request or result beat resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        idle_enable = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pops and query on the empty deque, value extremes at both
        // ends (push front right after reset wraps the head), spare codes with
        // a nonzero payload, pops from both ends down to empty and past it.
        send_request(REQ_QUERY,      32'h0000_0000);
        send_request(REQ_POP_FRONT,  32'h1234_5678);
        send_request(REQ_POP_BACK,   32'hFFFF_FFFF);
        send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(REQ_PUSH_BACK,  32'h8000_0000);
        send_request(REQ_PUSH_FRONT, 32'h0000_0000);
        send_request(REQ_PUSH_BACK,  32'hFFFF_FFFF);
        send_request(REQ_QUERY,      32'hFFFF_FFFF);
        send_request(REQ_SPARE_A,    32'hDEAD_BEEF);
        send_request(REQ_SPARE_B,    32'h8000_0000);
        send_request(REQ_SPARE_C,    32'h7FFF_FFFF);
        send_request(REQ_POP_BACK,   32'h0000_0001);
        send_request(REQ_POP_FRONT,  32'h0000_0000);
        send_request(REQ_POP_FRONT,  32'h0000_0000);
        send_request(REQ_PUSH_BACK,  32'h5555_5555);
        send_request(REQ_PUSH_FRONT, 32'hAAAA_AAAA);
        send_request(REQ_POP_BACK,   32'h0000_0000);
        send_request(REQ_POP_BACK,   32'h0000_0000);
        send_request(REQ_POP_FRONT,  32'h0000_0000);
        send_request(REQ_POP_BACK,   32'h0000_0000);
        send_request(REQ_POP_FRONT,  32'h0000_0000);
        wait_until_drained();

        // Pop-heavy mix near empty: frequent pops on the empty deque.
        for (int i = 0; i < MIX_ITEMS; i++)
        begin
            send_random(40, 50);
        end

        // Fill to full with pushes at both ends, head wrapping around the ring;
        // the tail of this run pushes into the full deque. A stretch in the
        // middle runs back to back with no idle cycles.
        for (int i = 0; i < FILL_ITEMS; i++)
        begin
            idle_enable = !(i >= 200 && i < 600);
            send_random(98, 1);
        end
        idle_enable = 1'b1;
        wait_until_drained();

        // Churn at full: pops make room, most pushes refill or get refused.
        for (int i = 0; i < MIX_ITEMS; i++)
        begin
            send_random(55, 35);
        end
        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending != 0)
        begin
            $error("%0d result beats never arrived", pending);
        end
        if (mismatches == 0 && pending == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ double_ended_queue.f @@
sv/dq_pkg.sv
sv/dq_cell.sv
sv/dq_chain.sv
sv/double_ended_queue.sv
bench/deque_checker.sv
bench/double_ended_queue_tb.sv
